[rtl/servo_packet_framer_queue_macros.svh]
// ----------------------------------------------------------------------------
// servo_packet_framer_queue_macros
// Assertion macros shared by the framer checker.
// ----------------------------------------------------------------------------
`ifndef SERVO_PACKET_FRAMER_QUEUE_MACROS_SVH
`define SERVO_PACKET_FRAMER_QUEUE_MACROS_SVH

// check on every clock edge outside reset
`define SPFQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define SPFQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/spfq_pkg.sv]
// ----------------------------------------------------------------------------
// spfq_pkg
// Types, constants and helpers for the servo packet framer queue.
// ----------------------------------------------------------------------------
package spfq_pkg;

	localparam int FRAME_SLOTS = 16;
	localparam int FRAME_BYTES = 20;
	localparam int Q_DEPTH     = 4;

	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int POS_W  = $clog2(FRAME_BYTES + 1);
	localparam int ADDR_W = $clog2(FRAME_SLOTS * FRAME_BYTES);
	localparam int Q_AW   = $clog2(Q_DEPTH);
	localparam int HDR_BYTES = 5;
	localparam int FRAME_OVERHEAD = 6;

	localparam logic [7:0] SYNC_BYTE = 8'hff;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		CMD_BEGIN   = 2'd0,
		CMD_PAYLOAD = 2'd1,
		CMD_TICK    = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_RING_FULL  = 3'd1,
		ST_RING_EMPTY = 3'd2,
		ST_TOO_LONG   = 3'd3,
		ST_UNEXPECTED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_COLLECT,
		MODE_DROP_FULL,
		MODE_DROP_LONG
	} collect_mode_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_HDR,
		BK_CSUM,
		BK_TX
	} back_state_t;

	typedef struct packed {
		cmd_t       kind;
		logic [7:0] servo_id;
		logic [7:0] length_value;
		logic [7:0] instruction;
		logic [7:0] payload_byte;
		logic [7:0] count;
		logic       too_long;
	} op_t;

	function automatic slot_t next_slot(input slot_t s);
		next_slot = (s == slot_t'(FRAME_SLOTS - 1)) ? '0 : slot_t'(s + 1'b1);
	endfunction

	function automatic addr_t frame_addr(input slot_t s, input pos_t p);
		frame_addr = addr_t'(addr_t'(s) * addr_t'(FRAME_BYTES) + addr_t'(p));
	endfunction

endpackage

[rtl/spfq_ram.sv]
// ----------------------------------------------------------------------------
// spfq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module spfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 320
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/spfq_front.sv]
// ----------------------------------------------------------------------------
// spfq_front
// Accept commands, classify them and hold them in a short queue.
// ----------------------------------------------------------------------------
module spfq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     command,
	input  logic [7:0]     servo_id,
	input  logic [7:0]     length_value,
	input  logic [7:0]     instruction,
	input  logic [7:0]     payload_byte,
	output logic           busy,
	output logic           op_valid,
	output spfq_pkg::op_t  op,
	input  logic           op_pop
);

	spfq_pkg::op_t                 q_mem_q [spfq_pkg::Q_DEPTH];
	logic [spfq_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [spfq_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [spfq_pkg::Q_AW:0]       cnt_q;
	logic                          push;
	logic                          do_pop;
	logic                          keep;
	spfq_pkg::op_t                 new_op;
	logic [7:0]                    count;

	assign busy     = (cnt_q == (spfq_pkg::Q_AW + 1)'(spfq_pkg::Q_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op       = q_mem_q[rd_ptr_q];
	assign do_pop   = op_pop && op_valid;

	always_comb begin
		unique case (spfq_pkg::cmd_t'(command)) inside
			spfq_pkg::CMD_BEGIN, spfq_pkg::CMD_PAYLOAD, spfq_pkg::CMD_TICK: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign push  = start && !busy && keep;
	assign count = (length_value >= 8'd2) ? 8'(length_value - 8'd2) : 8'd0;

	always_comb begin
		new_op.kind         = spfq_pkg::cmd_t'(command);
		new_op.servo_id     = servo_id;
		new_op.length_value = length_value;
		new_op.instruction  = instruction;
		new_op.payload_byte = payload_byte;
		new_op.count        = count;
		new_op.too_long     = (9'(count) + 9'(spfq_pkg::FRAME_OVERHEAD))
			> 9'(spfq_pkg::FRAME_BYTES);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= spfq_pkg::Q_AW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= spfq_pkg::Q_AW'(rd_ptr_q + 1'b1);
			end
			if (push && !do_pop) begin
				cnt_q <= (spfq_pkg::Q_AW + 1)'(cnt_q + 1'b1);
			end else if (!push && do_pop) begin
				cnt_q <= (spfq_pkg::Q_AW + 1)'(cnt_q - 1'b1);
			end
		end
	end

endmodule

[rtl/spfq_back.sv]
// ----------------------------------------------------------------------------
// spfq_back
// Build frames into the slot ring and drain the oldest frame on a tick.
// ----------------------------------------------------------------------------
module spfq_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	input  spfq_pkg::op_t         op,
	output logic                  op_pop,
	output logic                  result_valid,
	output logic                  byte_valid,
	output logic [7:0]            tx_byte,
	output logic                  tx_last,
	output logic [2:0]            status
);

	spfq_pkg::back_state_t   state_q, state_d;
	spfq_pkg::collect_mode_t mode_q, mode_d;
	spfq_pkg::slot_t         write_slot_q, write_slot_d;
	spfq_pkg::slot_t         read_slot_q, read_slot_d;
	spfq_pkg::pos_t          fill_q, fill_d;
	logic [7:0]              sum_q, sum_d;
	logic [7:0]              remain_q, remain_d;
	logic [7:0]              id_q, id_d;
	logic [7:0]              len_q, len_d;
	logic [7:0]              instr_q, instr_d;
	spfq_pkg::pos_t          tx_len_q, tx_len_d;
	spfq_pkg::pos_t          tx_pos_q, tx_pos_d;
	spfq_pkg::pos_t          lengths_q [spfq_pkg::FRAME_SLOTS];
	logic                    len_we;

	logic                    res_valid_q, res_valid_d;
	logic                    res_byte_q, res_byte_d;
	logic                    res_last_q, res_last_d;
	spfq_pkg::status_t       res_status_q, res_status_d;

	logic                    ram_we;
	spfq_pkg::addr_t         ram_addr;
	logic [7:0]              ram_wdata;
	logic [7:0]              ram_rdata;
	logic [7:0]              hdr_byte;

	spfq_ram #(
		.WIDTH (8),
		.DEPTH (spfq_pkg::FRAME_SLOTS * spfq_pkg::FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign result_valid = res_valid_q;
	assign byte_valid   = res_byte_q;
	assign tx_byte      = res_byte_q ? ram_rdata : 8'd0;
	assign tx_last      = res_last_q;
	assign status       = res_status_q;

	always_comb begin
		case (fill_q)
			spfq_pkg::pos_t'(2): hdr_byte = id_q;
			spfq_pkg::pos_t'(3): hdr_byte = len_q;
			spfq_pkg::pos_t'(4): hdr_byte = instr_q;
			default:             hdr_byte = spfq_pkg::SYNC_BYTE;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		write_slot_d = write_slot_q;
		read_slot_d  = read_slot_q;
		fill_d       = fill_q;
		sum_d        = sum_q;
		remain_d     = remain_q;
		id_d         = id_q;
		len_d        = len_q;
		instr_d      = instr_q;
		tx_len_d     = tx_len_q;
		tx_pos_d     = tx_pos_q;
		len_we       = 1'b0;
		op_pop       = 1'b0;
		ram_we       = 1'b0;
		ram_wdata    = hdr_byte;
		ram_addr     = spfq_pkg::frame_addr(write_slot_q, fill_q);
		res_valid_d  = 1'b0;
		res_byte_d   = 1'b0;
		res_last_d   = 1'b0;
		res_status_d = spfq_pkg::ST_OK;

		unique case (state_q)
			spfq_pkg::BK_IDLE: begin
				if (op_valid) begin
					op_pop      = 1'b1;
					res_valid_d = 1'b1;
					res_last_d  = 1'b1;
					case (op.kind)
						spfq_pkg::CMD_BEGIN: begin
							remain_d = op.count;
							if (spfq_pkg::next_slot(write_slot_q) == read_slot_q) begin
								mode_d = (op.count != 8'd0) ? spfq_pkg::MODE_DROP_FULL
									: spfq_pkg::MODE_IDLE;
								res_status_d = spfq_pkg::ST_RING_FULL;
							end else if (op.too_long) begin
								mode_d       = spfq_pkg::MODE_DROP_LONG;
								res_status_d = spfq_pkg::ST_TOO_LONG;
							end else begin
								mode_d  = spfq_pkg::MODE_COLLECT;
								fill_d  = '0;
								id_d    = op.servo_id;
								len_d   = op.length_value;
								instr_d = op.instruction;
								sum_d   = 8'(op.servo_id + op.length_value + op.instruction);
								state_d = spfq_pkg::BK_HDR;
							end
						end
						spfq_pkg::CMD_PAYLOAD: begin
							if (mode_q == spfq_pkg::MODE_IDLE || remain_q == 8'd0) begin
								mode_d       = spfq_pkg::MODE_IDLE;
								remain_d     = 8'd0;
								res_status_d = spfq_pkg::ST_UNEXPECTED;
							end else if (mode_q == spfq_pkg::MODE_COLLECT) begin
								ram_we    = 1'b1;
								ram_wdata = op.payload_byte;
								fill_d    = spfq_pkg::pos_t'(fill_q + 1'b1);
								sum_d     = 8'(sum_q + op.payload_byte);
								remain_d  = 8'(remain_q - 8'd1);
								if (remain_q == 8'd1) begin
									state_d = spfq_pkg::BK_CSUM;
								end
							end else begin
								res_status_d = (mode_q == spfq_pkg::MODE_DROP_FULL)
									? spfq_pkg::ST_RING_FULL : spfq_pkg::ST_TOO_LONG;
								remain_d = 8'(remain_q - 8'd1);
								if (remain_q == 8'd1) begin
									mode_d = spfq_pkg::MODE_IDLE;
								end
							end
						end
						default: begin
							if (read_slot_q == write_slot_q) begin
								res_status_d = spfq_pkg::ST_RING_EMPTY;
							end else begin
								res_valid_d = 1'b0;
								res_last_d  = 1'b0;
								tx_len_d    = lengths_q[read_slot_q];
								tx_pos_d    = '0;
								state_d     = spfq_pkg::BK_TX;
							end
						end
					endcase
				end
			end
			spfq_pkg::BK_HDR: begin
				ram_we = 1'b1;
				fill_d = spfq_pkg::pos_t'(fill_q + 1'b1);
				if (fill_q == spfq_pkg::pos_t'(spfq_pkg::HDR_BYTES - 1)) begin
					state_d = (remain_q == 8'd0) ? spfq_pkg::BK_CSUM : spfq_pkg::BK_IDLE;
				end
			end
			spfq_pkg::BK_CSUM: begin
				ram_we       = 1'b1;
				ram_wdata    = ~sum_q;
				len_we       = 1'b1;
				write_slot_d = spfq_pkg::next_slot(write_slot_q);
				mode_d       = spfq_pkg::MODE_IDLE;
				remain_d     = 8'd0;
				fill_d       = spfq_pkg::pos_t'(fill_q + 1'b1);
				state_d      = spfq_pkg::BK_IDLE;
			end
			spfq_pkg::BK_TX: begin
				ram_addr    = spfq_pkg::frame_addr(read_slot_q, tx_pos_q);
				res_valid_d = 1'b1;
				res_byte_d  = 1'b1;
				res_last_d  = (tx_pos_q == spfq_pkg::pos_t'(tx_len_q - 1'b1));
				tx_pos_d    = spfq_pkg::pos_t'(tx_pos_q + 1'b1);
				if (res_last_d) begin
					read_slot_d = spfq_pkg::next_slot(read_slot_q);
					state_d     = spfq_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = spfq_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			lengths_q[write_slot_q] <= spfq_pkg::pos_t'(fill_q + 1'b1);
		end
		id_q     <= id_d;
		len_q    <= len_d;
		instr_q  <= instr_d;
		tx_len_q <= tx_len_d;
		tx_pos_q <= tx_pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= spfq_pkg::BK_IDLE;
			mode_q       <= spfq_pkg::MODE_IDLE;
			write_slot_q <= '0;
			read_slot_q  <= '0;
			fill_q       <= '0;
			sum_q        <= 8'd0;
			remain_q     <= 8'd0;
			res_valid_q  <= 1'b0;
			res_byte_q   <= 1'b0;
			res_last_q   <= 1'b0;
			res_status_q <= spfq_pkg::ST_OK;
		end else begin
			state_q      <= state_d;
			mode_q       <= mode_d;
			write_slot_q <= write_slot_d;
			read_slot_q  <= read_slot_d;
			fill_q       <= fill_d;
			sum_q        <= sum_d;
			remain_q     <= remain_d;
			res_valid_q  <= res_valid_d;
			res_byte_q   <= res_byte_d;
			res_last_q   <= res_last_d;
			res_status_q <= res_status_d;
		end
	end

endmodule

[rtl/servo_packet_framer_queue.sv]
// ----------------------------------------------------------------------------
// servo_packet_framer_queue
// Servo bus packet framer: builds FF FF id length instruction payload
// checksum frames into a ring of slots and sends the oldest on a tick.
// ----------------------------------------------------------------------------
// channel   handshake              signals
// command   start / busy           command servo_id length_value instruction
//                                  payload_byte
// result    result_valid (strobe)  byte_valid tx_byte tx_last status
//
// A four-entry command queue decouples intake from the frame builder.
// The builder, on the single port of the frame store, takes no new command
// while it writes the header, writes the checksum after the last payload
// byte (or header) or sends a frame on a tick. Results are registered.
// Reset clears all control state; the frame store needs no clearing.
// busy rises only while the command queue is full; results cannot stall.
// ----------------------------------------------------------------------------
module servo_packet_framer_queue (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [7:0] servo_id,
	input  logic [7:0] length_value,
	input  logic [7:0] instruction,
	input  logic [7:0] payload_byte,
	output logic       result_valid,
	output logic       byte_valid,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic [2:0] status
);

	logic          op_valid;
	logic          op_pop;
	spfq_pkg::op_t op;

	spfq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.servo_id     (servo_id),
		.length_value (length_value),
		.instruction  (instruction),
		.payload_byte (payload_byte),
		.busy         (busy),
		.op_valid     (op_valid),
		.op           (op),
		.op_pop       (op_pop)
	);

	spfq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op           (op),
		.op_pop       (op_pop),
		.result_valid (result_valid),
		.byte_valid   (byte_valid),
		.tx_byte      (tx_byte),
		.tx_last      (tx_last),
		.status       (status)
	);

endmodule

[rtl/spfq_checker.sv]
// ----------------------------------------------------------------------------
// spfq_checker
// Port-level checks on the framer result stream.
// ----------------------------------------------------------------------------
`include "servo_packet_framer_queue_macros.svh"

module spfq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       byte_valid,
	input logic [7:0] tx_byte,
	input logic       tx_last,
	input logic [2:0] status
);

	logic mid_frame;
	logic info_res;
	logic byte_res;

	assign info_res  = result_valid && !byte_valid;
	assign byte_res  = result_valid && byte_valid;
	assign mid_frame = byte_res && !tx_last;

	`SPFQ_ASSERT(a_info_shape, info_res |-> tx_last && tx_byte == 8'd0, "bad info result")
	`SPFQ_ASSERT(a_byte_ok, byte_res |-> status == spfq_pkg::ST_OK, "frame byte with bad status")
	`SPFQ_ASSERT(a_frame_runs, mid_frame |=> byte_res, "gap inside a frame")
	`SPFQ_ASSERT(a_frame_sync, byte_res && !$past(mid_frame) |-> tx_byte == 8'hff, "no sync byte")
	`SPFQ_ASSERT_ALWAYS(a_byte_strobe, !result_valid |-> !byte_valid, "byte_valid without strobe")

endmodule

bind servo_packet_framer_queue spfq_checker u_spfq_checker (.*);

[tb/tb_servo_packet_framer_queue.sv]
// ----------------------------------------------------------------------------
// tb_servo_packet_framer_queue
// Self-checking bench for the servo packet framer. A short directed list
// covers empty and full ring, length limits, stray payload, abandoned frames
// and the unused command. Random frame traffic follows, with fill and drain
// phases and bursty intake. Every result strobe is checked against the
// directed list's status or a frame predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_servo_packet_framer_queue;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 480;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int N_ROWS         = 21;

	typedef struct packed {
		logic               bv;
		logic [7:0]         data;
		logic               last;
		spfq_pkg::status_t  st;
	} tx_result_t;

	typedef struct packed {
		spfq_pkg::cmd_t     cmd;
		logic [7:0]         id;
		logic [7:0]         len;
		logic [7:0]         instr;
		logic [7:0]         pb;
		logic [4:0]         reps;
		logic               typed;
		spfq_pkg::status_t  st;
	} plan_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] command;
	logic [7:0] servo_id;
	logic [7:0] length_value;
	logic [7:0] instruction;
	logic [7:0] payload_byte;
	logic       result_valid;
	logic       byte_valid;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic [2:0] status;

	logic [7:0]              slot_bytes [spfq_pkg::FRAME_SLOTS][spfq_pkg::FRAME_BYTES];
	int                      slot_len [spfq_pkg::FRAME_SLOTS];
	int                      wr_slot;
	int                      rd_slot;
	int                      fill_pos;
	logic [7:0]              csum_acc;
	int                      pay_left;
	spfq_pkg::collect_mode_t mode;

	tx_result_t step_out[$];
	tx_result_t expected_tx[$];

	int mismatches;
	int n_items;
	int n_results;
	int frames_sent;
	int full_drops;
	int long_drops;
	int burst_left;
	int idle_cycles;

	plan_row_t dir_plan [N_ROWS] = '{
	'{spfq_pkg::CMD_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_RING_EMPTY},
	'{spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h5a, 5'd1,  1'b1, spfq_pkg::ST_UNEXPECTED},
	'{spfq_pkg::CMD_UNUSED,  8'hff, 8'hff, 8'hff, 8'hff, 5'd1,  1'b0, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_BEGIN,   8'hff, 8'h00, 8'h00, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_BEGIN,   8'h00, 8'h01, 8'hff, 8'hff, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_BEGIN,   8'h12, 8'h04, 8'h03, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hff, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 5'd3,  1'b0, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_RING_EMPTY},
	'{spfq_pkg::CMD_BEGIN,   8'h02, 8'h11, 8'h00, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_TOO_LONG},
	'{spfq_pkg::CMD_BEGIN,   8'haa, 8'hff, 8'h55, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_TOO_LONG},
	'{spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h3c, 5'd2,  1'b1, spfq_pkg::ST_TOO_LONG},
	'{spfq_pkg::CMD_BEGIN,   8'h05, 8'h04, 8'h01, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h11, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_BEGIN,   8'h06, 8'h03, 8'h02, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h22, 5'd1,  1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h33, 5'd1,  1'b1, spfq_pkg::ST_UNEXPECTED},
	'{spfq_pkg::CMD_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 5'd1,  1'b0, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_BEGIN,   8'h40, 8'h00, 8'h80, 8'h00, 5'd15, 1'b1, spfq_pkg::ST_OK},
	'{spfq_pkg::CMD_BEGIN,   8'h3c, 8'h04, 8'h01, 8'h00, 5'd1,  1'b1, spfq_pkg::ST_RING_FULL}
	};

	servo_packet_framer_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.servo_id     (servo_id),
		.length_value (length_value),
		.instruction  (instruction),
		.payload_byte (payload_byte),
		.result_valid (result_valid),
		.byte_valid   (byte_valid),
		.tx_byte      (tx_byte),
		.tx_last      (tx_last),
		.status       (status)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int step_slot(input int s);
		return (s == spfq_pkg::FRAME_SLOTS - 1) ? 0 : s + 1;
	endfunction

	function automatic void push_info(input spfq_pkg::status_t st);
		tx_result_t r;
		r.bv   = 1'b0;
		r.data = 8'h00;
		r.last = 1'b1;
		r.st   = st;
		step_out.push_back(r);
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		if (fill_pos < spfq_pkg::FRAME_BYTES)
			slot_bytes[wr_slot][fill_pos] = b;
		fill_pos++;
	endfunction

	function automatic void seal_frame();
		store_byte(~csum_acc);
		slot_len[wr_slot] = fill_pos;
		wr_slot  = step_slot(wr_slot);
		mode     = spfq_pkg::MODE_IDLE;
		pay_left = 0;
	endfunction

	function automatic void frame_model(input spfq_pkg::cmd_t cmd, input logic [7:0] id,
		input logic [7:0] len, input logic [7:0] instr, input logic [7:0] pb);
		int count;
		int n;
		tx_result_t r;
		step_out.delete();
		case (cmd)
			spfq_pkg::CMD_BEGIN: begin
				count = (len >= 2) ? int'(len) - 2 : 0;
				if (step_slot(wr_slot) == rd_slot) begin
					mode     = (count > 0) ? spfq_pkg::MODE_DROP_FULL : spfq_pkg::MODE_IDLE;
					pay_left = count;
					full_drops++;
					push_info(spfq_pkg::ST_RING_FULL);
				end else if (spfq_pkg::FRAME_OVERHEAD + count > spfq_pkg::FRAME_BYTES) begin
					mode     = spfq_pkg::MODE_DROP_LONG;
					pay_left = count;
					long_drops++;
					push_info(spfq_pkg::ST_TOO_LONG);
				end else begin
					fill_pos = 0;
					store_byte(spfq_pkg::SYNC_BYTE);
					store_byte(spfq_pkg::SYNC_BYTE);
					store_byte(id);
					store_byte(len);
					store_byte(instr);
					csum_acc = id + len + instr;
					pay_left = count;
					mode     = spfq_pkg::MODE_COLLECT;
					if (count == 0)
						seal_frame();
					push_info(spfq_pkg::ST_OK);
				end
			end
			spfq_pkg::CMD_PAYLOAD: begin
				if (mode == spfq_pkg::MODE_IDLE || pay_left == 0) begin
					mode     = spfq_pkg::MODE_IDLE;
					pay_left = 0;
					push_info(spfq_pkg::ST_UNEXPECTED);
				end else if (mode == spfq_pkg::MODE_COLLECT) begin
					store_byte(pb);
					csum_acc = csum_acc + pb;
					pay_left--;
					if (pay_left == 0)
						seal_frame();
					push_info(spfq_pkg::ST_OK);
				end else begin
					push_info((mode == spfq_pkg::MODE_DROP_FULL) ? spfq_pkg::ST_RING_FULL
						: spfq_pkg::ST_TOO_LONG);
					pay_left--;
					if (pay_left == 0)
						mode = spfq_pkg::MODE_IDLE;
				end
			end
			spfq_pkg::CMD_TICK: begin
				if (rd_slot == wr_slot) begin
					push_info(spfq_pkg::ST_RING_EMPTY);
				end else begin
					n = slot_len[rd_slot];
					if (n < 1)
						n = 1;
					if (n > spfq_pkg::FRAME_BYTES)
						n = spfq_pkg::FRAME_BYTES;
					for (int k = 0; k < n; k++) begin
						r.bv   = 1'b1;
						r.data = slot_bytes[rd_slot][k];
						r.last = (k == n - 1);
						r.st   = spfq_pkg::ST_OK;
						step_out.push_back(r);
					end
					rd_slot = step_slot(rd_slot);
					frames_sent++;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input spfq_pkg::cmd_t cmd, input logic [7:0] id,
		input logic [7:0] len, input logic [7:0] instr, input logic [7:0] pb,
		input logic typed, input spfq_pkg::status_t st);
		tx_result_t r;
		start        <= 1'b1;
		command      <= cmd;
		servo_id     <= id;
		length_value <= len;
		instruction  <= instr;
		payload_byte <= pb;
		do @(posedge clk); while (busy);
		frame_model(cmd, id, len, instr, pb);
		if (typed) begin
			r.bv   = 1'b0;
			r.data = 8'h00;
			r.last = 1'b1;
			r.st   = st;
			expected_tx.push_back(r);
		end else begin
			foreach (step_out[i])
				expected_tx.push_back(step_out[i]);
		end
		if (cmd != spfq_pkg::CMD_UNUSED)
			n_items++;
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
	endtask

	task automatic send_rand(input spfq_pkg::cmd_t cmd, input logic [7:0] id,
		input logic [7:0] len, input logic [7:0] instr, input logic [7:0] pb);
		send_item(cmd, id, len, instr, pb, 1'b0, spfq_pkg::ST_OK);
	endtask

	task automatic log_miss(input string what, input tx_result_t exp);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: exp bv/byte/last/st %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
				$realtime, what, exp.bv, exp.data, exp.last, exp.st,
				byte_valid, tx_byte, tx_last, status);
	endtask

	always @(posedge clk) begin
		tx_result_t exp;
		if (arst_n && result_valid) begin
			n_results++;
			if (expected_tx.size() == 0) begin
				exp = '0;
				log_miss("result with nothing pending", exp);
			end else begin
				exp = expected_tx.pop_front();
				if (byte_valid !== exp.bv || tx_byte !== exp.data || tx_last !== exp.last
					|| status !== exp.st)
					log_miss("result mismatch", exp);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results pending",
				idle_cycles, expected_tx.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int phase_left;
		bit fill_phase;
		int pick;
		int len;
		int cnt;
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = spfq_pkg::CMD_BEGIN;
		servo_id     = 8'h00;
		length_value = 8'h00;
		instruction  = 8'h00;
		payload_byte = 8'h00;
		idle_cycles  = 0;
		mismatches   = 0;
		n_items      = 0;
		n_results    = 0;
		frames_sent  = 0;
		full_drops   = 0;
		long_drops   = 0;
		burst_left   = $urandom_range(1, 16);
		wr_slot      = 0;
		rd_slot      = 0;
		fill_pos     = 0;
		csum_acc     = 8'h00;
		pay_left     = 0;
		mode         = spfq_pkg::MODE_IDLE;
		foreach (slot_len[i])
			slot_len[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_plan[i]) begin
			for (int k = 0; k < dir_plan[i].reps; k++)
				send_item(dir_plan[i].cmd, 8'(dir_plan[i].id + k), dir_plan[i].len,
					dir_plan[i].instr, 8'(dir_plan[i].pb + k), dir_plan[i].typed,
					dir_plan[i].st);
		end
		send_item(spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1,
			spfq_pkg::ST_RING_FULL);
		send_item(spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hfe, 1'b1,
			spfq_pkg::ST_RING_FULL);
		send_item(spfq_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h77, 1'b1,
			spfq_pkg::ST_UNEXPECTED);
		repeat (16)
			send_rand(spfq_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);

		n_items    = 0;
		phase_left = 0;
		fill_phase = 1'b1;
		while (n_items < RANDOM_ITEMS) begin
			if (phase_left <= 0) begin
				fill_phase = ~fill_phase;
				phase_left = $urandom_range(20, 60);
			end
			pick = $urandom_range(0, 99);
			if (pick < (fill_phase ? 65 : 30)) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					len = $urandom_range(0, 18);
				else if (pick < 90)
					len = $urandom_range(17, 255);
				else
					len = $urandom_range(0, 2);
				send_rand(spfq_pkg::CMD_BEGIN, 8'($urandom), 8'(len), 8'($urandom),
					8'($urandom));
				cnt = (len >= 2) ? len - 2 : 0;
				if (cnt > 14)
					cnt = $urandom_range(0, 4);
				if ($urandom_range(0, 9) == 0)
					cnt = $urandom_range(0, cnt);
				repeat (cnt)
					send_rand(spfq_pkg::CMD_PAYLOAD, 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom));
			end else if (pick < 93) begin
				send_rand(spfq_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
			end else if (pick < 97) begin
				send_rand(spfq_pkg::CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
			end else begin
				send_rand(spfq_pkg::CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
			end
			phase_left--;
		end
		repeat (18)
			send_rand(spfq_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom));

		start <= 1'b0;
		while (expected_tx.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d results: %0d frames sent, %0d ring-full drops, %0d length drops",
			n_results, frames_sent, full_drops, long_drops);
		$display("mismatch count %0d", mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/spfq_pkg.sv
rtl/spfq_ram.sv
rtl/spfq_front.sv
rtl/spfq_back.sv
rtl/servo_packet_framer_queue.sv
rtl/spfq_checker.sv
tb/tb_servo_packet_framer_queue.sv
